// File: src/ditp_pkg.sv
// ============================================================================
// ditp_pkg
// Shared types and constants of the depth image to point cloud converter.
// ============================================================================
package ditp_pkg;

    // Default sizing
    localparam int MAX_WIDTH_DEF       = 4096;
    localparam int MAX_HEIGHT_DEF      = 4096;
    localparam int DEPTH_BITS_DEF      = 16;
    localparam int QUEUE_ADDR_BITS_DEF = 2;

    // Field widths
    localparam int CFG_DIM_WIDTH = 13;
    localparam int SCALE_WIDTH   = 16;
    localparam int RAW_WIDTH     = 16;
    localparam int COLOR_WIDTH   = 32;
    localparam int POINT_WIDTH   = 40;
    localparam int Z_WIDTH       = 32;
    localparam int FRAC_BITS     = 17;
    localparam int PADDR_WIDTH   = 5;
    localparam int PDATA_WIDTH   = 32;

    // Saturation limits of the lateral coordinates
    localparam logic [POINT_WIDTH-1:0] SAT_POS = {1'b0, {(POINT_WIDTH-1){1'b1}}};
    localparam logic [POINT_WIDTH-1:0] SAT_NEG = {1'b1, {(POINT_WIDTH-1){1'b0}}};

    // Register map, word index
    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_X_SCALE       = 3'd2,
        REG_Y_SCALE       = 3'd3,
        REG_DEPTH_SCALE   = 3'd4,
        REG_INVALID_DEPTH = 3'd5
    } t_reg_index;

    typedef struct packed {
        logic [CFG_DIM_WIDTH-1:0] image_width;
        logic [CFG_DIM_WIDTH-1:0] image_height;
        logic [SCALE_WIDTH-1:0]   x_scale;
        logic [SCALE_WIDTH-1:0]   y_scale;
        logic [SCALE_WIDTH-1:0]   depth_scale;
        logic [RAW_WIDTH-1:0]     invalid_depth;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        image_width:   CFG_DIM_WIDTH'(640),
        image_height:  CFG_DIM_WIDTH'(480),
        x_scale:       '0,
        y_scale:       '0,
        depth_scale:   SCALE_WIDTH'(66),
        invalid_depth: '0
    };

    typedef struct packed {
        logic [RAW_WIDTH-1:0]   raw_depth;
        logic [COLOR_WIDTH-1:0] color;
    } t_in_item;

    typedef struct packed {
        logic signed [POINT_WIDTH-1:0] point_x;
        logic signed [POINT_WIDTH-1:0] point_y;
        logic [Z_WIDTH-1:0]            point_z;
        logic [COLOR_WIDTH-1:0]        color_out;
        logic                          frame_end;
    } t_out_item;

    // Classified pixel handed from front to back (offsets travel beside it)
    typedef struct packed {
        logic [RAW_WIDTH-1:0]   raw_depth;
        logic [COLOR_WIDTH-1:0] color;
        logic                   neg_x;
        logic                   neg_y;
        logic                   frame_end;
    } t_front_item;

endpackage

// File: src/ditp_front.sv
// ============================================================================
// ditp_front
// Tracks the pixel position, flags invalid depth and frame end, and forms the
// signed offsets |2*col - width| and |2*row - height| of each item.
// ============================================================================
module ditp_front #(
    parameter int  MAX_WIDTH  = ditp_pkg::MAX_WIDTH_DEF,
    parameter int  MAX_HEIGHT = ditp_pkg::MAX_HEIGHT_DEF,
    parameter int  DEPTH_BITS = ditp_pkg::DEPTH_BITS_DEF,
    localparam int CW  = $clog2(MAX_WIDTH),
    localparam int RW  = $clog2(MAX_HEIGHT),
    localparam int DXW = (CW + 1 > ditp_pkg::CFG_DIM_WIDTH) ? CW + 1 : ditp_pkg::CFG_DIM_WIDTH,
    localparam int DYW = (RW + 1 > ditp_pkg::CFG_DIM_WIDTH) ? RW + 1 : ditp_pkg::CFG_DIM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  ditp_pkg::t_in_item    i_item,
    input  ditp_pkg::t_cfg        i_cfg,
    output ditp_pkg::t_front_item o_item,
    output logic [DXW-1:0]        o_dx,
    output logic [DYW-1:0]        o_dy
);

    localparam logic [ditp_pkg::RAW_WIDTH-1:0] DEPTH_MASK =
        (DEPTH_BITS >= ditp_pkg::RAW_WIDTH) ? {ditp_pkg::RAW_WIDTH{1'b1}} :
        ditp_pkg::RAW_WIDTH'((64'd1 << DEPTH_BITS) - 64'd1);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    logic [DXW-1:0] col_inc, col_twice, width_ext;
    logic [DYW-1:0] row_inc, row_twice, height_ext;
    logic           last_col, last_row;
    logic [ditp_pkg::RAW_WIDTH-1:0] raw_m;

    // Position compare and offsets
    always_comb begin
        col_inc    = DXW'(r_col) + DXW'(1);
        row_inc    = DYW'(r_row) + DYW'(1);
        col_twice  = DXW'({r_col, 1'b0});
        row_twice  = DYW'({r_row, 1'b0});
        width_ext  = DXW'(i_cfg.image_width);
        height_ext = DYW'(i_cfg.image_height);

        last_col = (col_inc >= width_ext) || (r_col == CW'(MAX_WIDTH - 1));
        last_row = (row_inc >= height_ext) || (r_row == RW'(MAX_HEIGHT - 1));

        o_item.neg_x = col_twice < width_ext;
        o_item.neg_y = row_twice < height_ext;
        o_dx = o_item.neg_x ? (width_ext - col_twice) : (col_twice - width_ext);
        o_dy = o_item.neg_y ? (height_ext - row_twice) : (row_twice - height_ext);

        // Invalid pixel travels as zero depth: all coordinates then come out zero
        raw_m              = i_item.raw_depth & DEPTH_MASK;
        o_item.raw_depth   = (raw_m == i_cfg.invalid_depth) ? '0 : raw_m;
        o_item.color       = i_item.color;
        o_item.frame_end   = last_col && last_row;
    end

    // Counter advance
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_take) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : RW'(row_inc);
            end else begin
                n_col = CW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// File: src/ditp_queue.sv
// ============================================================================
// ditp_queue
// Small show-ahead queue that decouples the front from the back.
// ============================================================================
module ditp_queue #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = ditp_pkg::QUEUE_ADDR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_avail
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0]   r_mem [DEPTH];
    logic [ADDR_BITS-1:0] r_wr, r_rd;
    logic [ADDR_BITS:0]   r_count;

    assign o_full  = r_count == (ADDR_BITS+1)'(DEPTH);
    assign o_avail = r_count != '0;
    assign o_data  = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + ADDR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + ADDR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (ADDR_BITS+1)'(1);
                2'b01:   r_count <= r_count - (ADDR_BITS+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: src/ditp_lateral.sv
// ============================================================================
// ditp_lateral
// One lateral coordinate: offset * z * scale / 2^17, floored, signed and
// saturated to 40 bits. Three register stages.
// ============================================================================
module ditp_lateral #(
    parameter int DW = ditp_pkg::CFG_DIM_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [DW-1:0]                       i_d,
    input  logic                                i_neg,
    input  logic [ditp_pkg::Z_WIDTH-1:0]        i_z,
    input  logic [ditp_pkg::SCALE_WIDTH-1:0]    i_scale,
    output logic [ditp_pkg::POINT_WIDTH-1:0]    o_point
);

    localparam int AW = DW + ditp_pkg::Z_WIDTH;
    localparam int HW = AW - ditp_pkg::FRAC_BITS;
    localparam int PW = HW + ditp_pkg::SCALE_WIDTH;
    localparam int LW = ditp_pkg::FRAC_BITS + ditp_pkg::SCALE_WIDTH;
    localparam int MW = PW + 1;
    localparam int SW = ditp_pkg::POINT_WIDTH - 1;

    logic [AW-1:0] r_a;
    logic          r_neg1, r_neg2;
    logic [PW-1:0] r_hi;
    logic [LW-1:0] r_lo;
    logic [ditp_pkg::POINT_WIDTH-1:0] r_res, n_res;

    logic [MW-1:0] mag, mag_up;
    logic          rem;

    // Stage 1: offset times depth
    // Stage 2: upper and lower parts of the product times scale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= AW'(i_d) * AW'(i_z);
            r_neg1 <= i_neg;
            r_hi   <= PW'(r_a[AW-1:ditp_pkg::FRAC_BITS]) * PW'(i_scale);
            r_lo   <= LW'(r_a[ditp_pkg::FRAC_BITS-1:0]) * LW'(i_scale);
            r_neg2 <= r_neg1;
            r_res  <= n_res;
        end
    end

    // Stage 3: combine, floor toward minus infinity, saturate
    always_comb begin
        mag    = MW'(r_hi) + MW'(r_lo[LW-1:ditp_pkg::FRAC_BITS]);
        rem    = |r_lo[ditp_pkg::FRAC_BITS-1:0];
        mag_up = mag + MW'(rem);
        if (!r_neg2) begin
            n_res = (|mag[MW-1:SW]) ? ditp_pkg::SAT_POS : mag[ditp_pkg::POINT_WIDTH-1:0];
        end else begin
            n_res = (|mag_up[MW-1:SW]) ? ditp_pkg::SAT_NEG :
                    (~mag_up[ditp_pkg::POINT_WIDTH-1:0] + ditp_pkg::POINT_WIDTH'(1));
        end
    end

    assign o_point = r_res;

endmodule

// File: src/ditp_back.sv
// ============================================================================
// ditp_back
// Arithmetic pipeline: depth scaling, then both lateral lanes, then the
// output register. The whole pipeline advances when the output is free.
// ============================================================================
module ditp_back #(
    parameter int DXW = ditp_pkg::CFG_DIM_WIDTH,
    parameter int DYW = ditp_pkg::CFG_DIM_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_avail,
    output logic                  o_take,
    input  ditp_pkg::t_front_item i_item,
    input  logic [DXW-1:0]        i_dx,
    input  logic [DYW-1:0]        i_dy,
    input  ditp_pkg::t_cfg        i_cfg,
    output logic                  o_valid,
    input  logic                  i_pop,
    output ditp_pkg::t_out_item   o_item
);

    localparam int NSTG = 4;

    logic en;

    // Stage 0 payload
    logic [ditp_pkg::Z_WIDTH-1:0] r_z0;
    logic [DXW-1:0]               r_dx0;
    logic [DYW-1:0]               r_dy0;
    logic                         r_negx0, r_negy0;

    // Side pipeline, stage 0 to output
    logic [NSTG-1:0]                  r_v;
    logic [ditp_pkg::Z_WIDTH-1:0]     r_z     [1:NSTG-1];
    logic [ditp_pkg::COLOR_WIDTH-1:0] r_color [NSTG];
    logic                             r_fend  [NSTG];

    logic [ditp_pkg::POINT_WIDTH-1:0] px, py;

    assign en     = !r_v[NSTG-1] || i_pop;
    assign o_take = en && i_avail;

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_avail};
        end
    end

    // Depth scaling and side data
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z0       <= ditp_pkg::Z_WIDTH'(i_item.raw_depth) *
                          ditp_pkg::Z_WIDTH'(i_cfg.depth_scale);
            r_dx0      <= i_dx;
            r_dy0      <= i_dy;
            r_negx0    <= i_item.neg_x;
            r_negy0    <= i_item.neg_y;
            r_color[0] <= i_item.color;
            r_fend[0]  <= i_item.frame_end;
            r_z[1]     <= r_z0;
            for (int s = 1; s < NSTG; s++) begin
                r_color[s] <= r_color[s-1];
                r_fend[s]  <= r_fend[s-1];
            end
            for (int s = 2; s < NSTG; s++) begin
                r_z[s] <= r_z[s-1];
            end
        end
    end

    ditp_lateral #(.DW(DXW)) u_lane_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_d     (r_dx0),
        .i_neg   (r_negx0),
        .i_z     (r_z0),
        .i_scale (i_cfg.x_scale),
        .o_point (px)
    );

    ditp_lateral #(.DW(DYW)) u_lane_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_d     (r_dy0),
        .i_neg   (r_negy0),
        .i_z     (r_z0),
        .i_scale (i_cfg.y_scale),
        .o_point (py)
    );

    // Output register view
    assign o_valid          = r_v[NSTG-1];
    assign o_item.point_x   = px;
    assign o_item.point_y   = py;
    assign o_item.point_z   = r_z[NSTG-1];
    assign o_item.color_out = r_color[NSTG-1];
    assign o_item.frame_end = r_fend[NSTG-1];

endmodule

// File: src/depth_image_to_points.sv
// ============================================================================
// depth_image_to_points
// Back-projects raster-ordered raw depth pixels into 3D points.
// ============================================================================
// Usage:
//   Input side is a queue write port: drive i_in_item and raise push while
//   full is low; each accepted item is one pixel, in raster order.
//   Result side is a queue read port: while empty is low, o_out_item holds the
//   oldest point; raise pop to take it. One point per pixel, in order.
//   Registers are written over the APB port at byte address 4*index; pready
//   is tied high, reads return the value. The user writes them only while
//   no pixel is in flight; the block does not enforce this.
// Path: an accepted pixel passes queue read with depth multiply, offset
//   multiply, scale multiply and saturation before empty goes low.
// Throughput: one pixel per cycle; set by the single-issue arithmetic
//   pipeline, which advances whenever its output register is free.
// Stall: when pop stays low the pipeline holds, the front queue fills and
//   full rises; the position counters only move on accepted pixels.
// Reset: synchronous, active low. Counters start at column 0, row 0, the
//   queue and pipeline empty, registers at their reset values.
// ============================================================================
module depth_image_to_points #(
    parameter int MAX_WIDTH       = ditp_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT      = ditp_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS      = ditp_pkg::DEPTH_BITS_DEF,
    parameter int QUEUE_ADDR_BITS = ditp_pkg::QUEUE_ADDR_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ditp_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [ditp_pkg::PDATA_WIDTH-1:0]   pwdata,
    output logic [ditp_pkg::PDATA_WIDTH-1:0]   prdata,
    output logic                               pready,
    // pixels in
    input  logic                               push,
    output logic                               full,
    input  ditp_pkg::t_in_item                 i_in_item,
    // points out
    output logic                               empty,
    input  logic                               pop,
    output ditp_pkg::t_out_item                o_out_item
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DXW = (CW + 1 > ditp_pkg::CFG_DIM_WIDTH) ? CW + 1 : ditp_pkg::CFG_DIM_WIDTH;
    localparam int DYW = (RW + 1 > ditp_pkg::CFG_DIM_WIDTH) ? RW + 1 : ditp_pkg::CFG_DIM_WIDTH;
    localparam int QW  = $bits(ditp_pkg::t_front_item) + DXW + DYW;

    ditp_pkg::t_cfg         r_cfg;
    ditp_pkg::t_reg_index   reg_sel;
    ditp_pkg::t_front_item  f_item, q_item;
    logic [DXW-1:0]         f_dx, q_dx;
    logic [DYW-1:0]         f_dy, q_dy;
    logic [QW-1:0]          q_out;
    logic                   push_ok, q_avail, q_take, out_valid;

    assign pready  = 1'b1;
    assign reg_sel = ditp_pkg::t_reg_index'(paddr[ditp_pkg::PADDR_WIDTH-1:2]);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= ditp_pkg::CFG_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                ditp_pkg::REG_IMAGE_WIDTH:
                    r_cfg.image_width   <= pwdata[ditp_pkg::CFG_DIM_WIDTH-1:0];
                ditp_pkg::REG_IMAGE_HEIGHT:
                    r_cfg.image_height  <= pwdata[ditp_pkg::CFG_DIM_WIDTH-1:0];
                ditp_pkg::REG_X_SCALE:
                    r_cfg.x_scale       <= pwdata[ditp_pkg::SCALE_WIDTH-1:0];
                ditp_pkg::REG_Y_SCALE:
                    r_cfg.y_scale       <= pwdata[ditp_pkg::SCALE_WIDTH-1:0];
                ditp_pkg::REG_DEPTH_SCALE:
                    r_cfg.depth_scale   <= pwdata[ditp_pkg::SCALE_WIDTH-1:0];
                ditp_pkg::REG_INVALID_DEPTH:
                    r_cfg.invalid_depth <= pwdata[ditp_pkg::RAW_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_sel)
            ditp_pkg::REG_IMAGE_WIDTH:   prdata = ditp_pkg::PDATA_WIDTH'(r_cfg.image_width);
            ditp_pkg::REG_IMAGE_HEIGHT:  prdata = ditp_pkg::PDATA_WIDTH'(r_cfg.image_height);
            ditp_pkg::REG_X_SCALE:       prdata = ditp_pkg::PDATA_WIDTH'(r_cfg.x_scale);
            ditp_pkg::REG_Y_SCALE:       prdata = ditp_pkg::PDATA_WIDTH'(r_cfg.y_scale);
            ditp_pkg::REG_DEPTH_SCALE:   prdata = ditp_pkg::PDATA_WIDTH'(r_cfg.depth_scale);
            ditp_pkg::REG_INVALID_DEPTH: prdata = ditp_pkg::PDATA_WIDTH'(r_cfg.invalid_depth);
            default:                     prdata = '0;
        endcase
    end

    assign push_ok = push && !full;

    ditp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (push_ok),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .o_item  (f_item),
        .o_dx    (f_dx),
        .o_dy    (f_dy)
    );

    ditp_queue #(
        .WIDTH     (QW),
        .ADDR_BITS (QUEUE_ADDR_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_ok),
        .i_data  ({f_item, f_dx, f_dy}),
        .o_full  (full),
        .i_pop   (q_take),
        .o_data  (q_out),
        .o_avail (q_avail)
    );

    assign {q_item, q_dx, q_dy} = q_out;

    ditp_back #(
        .DXW (DXW),
        .DYW (DYW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .o_take  (q_take),
        .i_item  (q_item),
        .i_dx    (q_dx),
        .i_dy    (q_dy),
        .i_cfg   (r_cfg),
        .o_valid (out_valid),
        .i_pop   (pop),
        .o_item  (o_out_item)
    );

    assign empty = !out_valid;

endmodule

// File: src/ditp_checker.sv
// ============================================================================
// ditp_checker
// Port-level checks of the depth image to point cloud converter.
// ============================================================================
module ditp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input ditp_pkg::t_out_item o_out_item
);

    // Reset leaves both sides open and no point pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not clear after reset");

    // Zero depth means the pixel projects onto the origin
    a_zero_depth_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_out_item.point_z == '0)) |->
        ((o_out_item.point_x == '0) && (o_out_item.point_y == '0)))
        else $error("nonzero lateral coordinate at zero depth");

    // A point never appears without a pixel in flight
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !push && $past(empty) && !$past(push) && $past(empty, 2) &&
         !$past(push, 2) && $past(empty, 3) && !$past(push, 3) &&
         $past(empty, 4) && !$past(push, 4)) |=> empty)
        else $error("point produced without a pixel in flight");

    // A waiting point holds while not taken
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_item)))
        else $error("pending point changed while stalled");

endmodule

bind depth_image_to_points ditp_checker u_ditp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_item (o_out_item)
);

// File: tb/sv/depth_image_to_points_tb.sv
// ----------------------------------------------------------------------------
// depth_image_to_points_tb
// Self-checking bench for the depth image to point converter. A directed
// table covers the reset settings, invalid pixels, lateral saturation, a
// frame shrunk while it is running, and zero-sized frames. Random traffic
// follows under changing register settings and idle patterns. Every point
// is checked against a typed value or a behavioral back-projection of its pixel.
// ----------------------------------------------------------------------------
module depth_image_to_points_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int STAGE_ITEMS  = 600;

    typedef enum logic [0:0] {
        STEP_PIXEL = 1'b0,
        STEP_WRITE = 1'b1
    } t_step_kind;

    // One row of the directed table: a pixel or a register write
    typedef struct packed {
        t_step_kind           kind;
        ditp_pkg::t_reg_index reg_idx;
        logic [31:0]          value;
        ditp_pkg::t_in_item   pixel;
        logic                 typed;
        ditp_pkg::t_out_item  want;
    } t_plan_step;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ditp_pkg::PADDR_WIDTH-1:0] paddr;
    logic [ditp_pkg::PDATA_WIDTH-1:0] pwdata;
    logic [ditp_pkg::PDATA_WIDTH-1:0] prdata;
    logic pready;
    logic push;
    logic full;
    ditp_pkg::t_in_item in_item;
    logic empty;
    logic pop;
    ditp_pkg::t_out_item out_item;

    // Expected points, oldest first
    ditp_pkg::t_out_item point_q[$];
    t_plan_step directed_plan[$];

    // Shadow registers and raster position of the next pixel
    ditp_pkg::t_cfg cfg_shadow = ditp_pkg::CFG_RESET;
    logic [11:0] col_pos = '0;
    logic [11:0] row_pos = '0;

    int err_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 18;
    int receiver_idle_pct = 59;
    bit hold_request = 1'b0;

    depth_image_to_points i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .i_in_item  (in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (out_item)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("depth_image_to_points_tb failed");
            $finish;
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    // (2*pos - size) * z * scale / 2^17, floored and clamped to 40 bits
    function automatic logic [39:0] lateral_coord(logic [11:0] pos, logic [12:0] size,
                                                  logic [31:0] z, logic [15:0] scale);
        logic [63:0] twice;
        logic [63:0] offset;
        logic [63:0] prod;
        logic [63:0] low_part;
        logic [63:0] mag;
        logic [63:0] neg_mag;
        logic neg;
        logic rem;
        twice = 64'(pos) << 1;
        neg = twice < 64'(size);
        offset = neg ? (64'(size) - twice) : (twice - 64'(size));
        prod = offset * 64'(z);
        low_part = (prod & 64'h1_FFFF) * 64'(scale);
        mag = (prod >> ditp_pkg::FRAC_BITS) * 64'(scale) + (low_part >> ditp_pkg::FRAC_BITS);
        rem = (low_part & 64'h1_FFFF) != 64'd0;
        if (!neg)
            return (mag > 64'(ditp_pkg::SAT_POS)) ? ditp_pkg::SAT_POS : mag[39:0];
        if (rem)
            mag = mag + 64'd1;
        if (mag >= 64'(ditp_pkg::SAT_NEG))
            return ditp_pkg::SAT_NEG;
        neg_mag = 64'd0 - mag;
        return neg_mag[39:0];
    endfunction

    // Back-project one pixel at the current position, then step the raster
    function automatic ditp_pkg::t_out_item project_pixel(ditp_pkg::t_in_item px);
        ditp_pkg::t_out_item pt;
        logic [31:0] z;
        logic end_col;
        logic end_row;
        pt = '0;
        pt.color_out = px.color;
        if (px.raw_depth != cfg_shadow.invalid_depth) begin
            z = 32'(px.raw_depth) * 32'(cfg_shadow.depth_scale);
            pt.point_z = z;
            pt.point_x = lateral_coord(col_pos, cfg_shadow.image_width, z,
                                       cfg_shadow.x_scale);
            pt.point_y = lateral_coord(row_pos, cfg_shadow.image_height, z,
                                       cfg_shadow.y_scale);
        end
        end_col = (int'(col_pos) + 1 >= int'(cfg_shadow.image_width))
               || (int'(col_pos) + 1 >= ditp_pkg::MAX_WIDTH_DEF);
        end_row = (int'(row_pos) + 1 >= int'(cfg_shadow.image_height))
               || (int'(row_pos) + 1 >= ditp_pkg::MAX_HEIGHT_DEF);
        pt.frame_end = end_col && end_row;
        if (end_col) begin
            col_pos = '0;
            row_pos = end_row ? 12'd0 : row_pos + 12'd1;
        end else begin
            col_pos = col_pos + 12'd1;
        end
        return pt;
    endfunction

    function automatic ditp_pkg::t_out_item typed_point(logic [39:0] x, logic [39:0] y,
                                                        logic [31:0] z, logic [31:0] color);
        ditp_pkg::t_out_item pt;
        pt.point_x = x;
        pt.point_y = y;
        pt.point_z = z;
        pt.color_out = color;
        pt.frame_end = 1'b0;
        return pt;
    endfunction

    function automatic t_plan_step pixel_row(logic [15:0] raw, logic [31:0] color);
        t_plan_step st;
        st = '0;
        st.kind = STEP_PIXEL;
        st.pixel.raw_depth = raw;
        st.pixel.color = color;
        return st;
    endfunction

    function automatic t_plan_step typed_row(logic [15:0] raw, logic [31:0] color,
                                             ditp_pkg::t_out_item want);
        t_plan_step st;
        st = pixel_row(raw, color);
        st.typed = 1'b1;
        st.want = want;
        return st;
    endfunction

    function automatic t_plan_step write_row(ditp_pkg::t_reg_index ri, logic [31:0] value);
        t_plan_step st;
        st = '0;
        st.kind = STEP_WRITE;
        st.reg_idx = ri;
        st.value = value;
        return st;
    endfunction

    // Append one row to the directed table
    function automatic void plan_add(t_plan_step st);
        directed_plan.insert(directed_plan.size(), st);
    endfunction

    function automatic ditp_pkg::t_in_item random_pixel();
        ditp_pkg::t_in_item px;
        px.color = $urandom();
        case ($urandom_range(9))
            0: px.raw_depth = cfg_shadow.invalid_depth;
            1: px.raw_depth = 16'hFFFF;
            2: px.raw_depth = 16'($urandom_range(15));
            default: px.raw_depth = 16'($urandom_range(16'hFFFF));
        endcase
        return px;
    endfunction

    // Mostly small frames so that rows and frames close often
    function automatic logic [31:0] random_reg_value(ditp_pkg::t_reg_index ri);
        int pick;
        pick = $urandom_range(7);
        if (ri == ditp_pkg::REG_IMAGE_WIDTH || ri == ditp_pkg::REG_IMAGE_HEIGHT) begin
            case (pick)
                0: return 32'd0;
                1: return 32'd8191;
                2: return 32'd4096;
                3: return 32'($urandom_range(8191));
                default: return 32'($urandom_range(1, 6));
            endcase
        end
        case (pick)
            0: return 32'd0;
            1: return 32'hFFFF;
            2: return 32'($urandom_range(15));
            default: return 32'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // APB write, then read back the same register
    task automatic write_reg(ditp_pkg::t_reg_index ri, logic [31:0] value);
        logic [31:0] got;
        logic [31:0] stored;
        stored = (ri == ditp_pkg::REG_IMAGE_WIDTH || ri == ditp_pkg::REG_IMAGE_HEIGHT) ?
                 (value & 32'h1FFF) : (value & 32'hFFFF);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ri, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (ri)
            ditp_pkg::REG_IMAGE_WIDTH:   cfg_shadow.image_width = stored[12:0];
            ditp_pkg::REG_IMAGE_HEIGHT:  cfg_shadow.image_height = stored[12:0];
            ditp_pkg::REG_X_SCALE:       cfg_shadow.x_scale = stored[15:0];
            ditp_pkg::REG_Y_SCALE:       cfg_shadow.y_scale = stored[15:0];
            ditp_pkg::REG_DEPTH_SCALE:   cfg_shadow.depth_scale = stored[15:0];
            ditp_pkg::REG_INVALID_DEPTH: cfg_shadow.invalid_depth = stored[15:0];
            default: ;
        endcase
        // back-to-back read of the same address
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", 64'(stored), 64'(got));
    endtask

    // Offer one pixel, wait for it to be taken, queue its expected point
    task automatic send_pixel(ditp_pkg::t_in_item px, logic use_typed,
                              ditp_pkg::t_out_item typed_want);
        ditp_pkg::t_out_item predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        in_item <= px;
        do @(posedge i_clk); while (full);
        predicted = project_pixel(px);
        point_q.insert(point_q.size(), use_typed ? typed_want : predicted);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (point_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Phases of random length, each under a fresh mix of register values
    task automatic run_stage(int n_items);
        int sent;
        int len;
        ditp_pkg::t_reg_index ri;
        sent = 0;
        while (sent < n_items) begin
            wait_drained();
            ri = ri.first();
            forever begin
                if ($urandom_range(1) == 1)
                    write_reg(ri, random_reg_value(ri));
                if (ri == ri.last())
                    break;
                ri = ri.next();
            end
            len = $urandom_range(10, 90);
            repeat (len) send_pixel(random_pixel(), 1'b0, '0);
            sent += len;
        end
    endtask

    // Result side: random pop, with one long hold on request
    initial begin : point_sink
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Compare each taken point with the oldest expectation
    always @(posedge i_clk) begin : point_check
        ditp_pkg::t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (point_q.size() == 0) begin
                $display("%0t ns: point expected none, got %h", $time, out_item);
                err_count++;
            end else begin
                want = point_q.pop_front();
                check_field("point_x", 64'(want.point_x), 64'(out_item.point_x));
                check_field("point_y", 64'(want.point_y), 64'(out_item.point_y));
                check_field("point_z", 64'(want.point_z), 64'(out_item.point_z));
                check_field("color_out", 64'(want.color_out), 64'(out_item.color_out));
                check_field("frame_end", 64'(want.frame_end), 64'(out_item.frame_end));
            end
        end
    end

    // Main sequence
    initial begin : stimulus
        t_plan_step st;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        push = 1'b0;
        in_item = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: invalid zero pixel, full-scale pixel, x and y zero
        plan_add(typed_row(16'h0000, 32'h0000_0000,
                           typed_point('0, '0, 32'h0, 32'h0)));
        plan_add(typed_row(16'hFFFF, 32'hFFFF_FFFF,
                           typed_point('0, '0, 32'h0041_FFBE, 32'hFFFF_FFFF)));
        plan_add(pixel_row(16'h0001, 32'h00A5_A5A5));
        // widest frame and largest scales: both lateral coordinates clamp low
        plan_add(write_row(ditp_pkg::REG_IMAGE_WIDTH, 32'd8191));
        plan_add(write_row(ditp_pkg::REG_IMAGE_HEIGHT, 32'd8191));
        plan_add(write_row(ditp_pkg::REG_X_SCALE, 32'hFFFF));
        plan_add(write_row(ditp_pkg::REG_Y_SCALE, 32'hFFFF));
        plan_add(write_row(ditp_pkg::REG_DEPTH_SCALE, 32'hFFFF));
        plan_add(write_row(ditp_pkg::REG_INVALID_DEPTH, 32'h1234));
        plan_add(typed_row(16'hFFFF, 32'h1234_5678,
                           typed_point(ditp_pkg::SAT_NEG, ditp_pkg::SAT_NEG,
                                       32'hFFFE_0001, 32'h1234_5678)));
        plan_add(typed_row(16'h1234, 32'h0000_0000,
                           typed_point('0, '0, 32'h0, 32'h0)));
        plan_add(pixel_row(16'h0000, 32'hFFFF_FFFF));
        plan_add(pixel_row(16'h8000, 32'h5A5A_5A5A));
        // frame shrunk below the running column: next pixel closes the row
        plan_add(write_row(ditp_pkg::REG_IMAGE_WIDTH, 32'd2));
        plan_add(write_row(ditp_pkg::REG_IMAGE_HEIGHT, 32'd3));
        plan_add(write_row(ditp_pkg::REG_X_SCALE, 32'h8000));
        plan_add(write_row(ditp_pkg::REG_Y_SCALE, 32'h0001));
        plan_add(write_row(ditp_pkg::REG_DEPTH_SCALE, 32'h0001));
        plan_add(write_row(ditp_pkg::REG_INVALID_DEPTH, 32'hFFFF));
        plan_add(pixel_row(16'hFFFF, 32'h8000_0001));
        plan_add(pixel_row(16'h0003, 32'h0F0F_0F0F));
        plan_add(pixel_row(16'h7FFF, 32'hF0F0_F0F0));
        plan_add(pixel_row(16'h0001, 32'h3333_3333));
        plan_add(pixel_row(16'hFFFE, 32'hCCCC_CCCC));
        plan_add(pixel_row(16'h4000, 32'h0000_0001));
        plan_add(pixel_row(16'h0100, 32'h8000_0000));
        // zero width and height: every pixel ends a frame
        plan_add(write_row(ditp_pkg::REG_IMAGE_WIDTH, 32'd0));
        plan_add(write_row(ditp_pkg::REG_IMAGE_HEIGHT, 32'd0));
        plan_add(pixel_row(16'h1111, 32'h1111_1111));
        plan_add(pixel_row(16'h0002, 32'hEEEE_EEEE));
        // one-pixel rows, zero height
        plan_add(write_row(ditp_pkg::REG_IMAGE_WIDTH, 32'd1));
        plan_add(pixel_row(16'h0FFF, 32'h2468_ACE0));
        plan_add(pixel_row(16'hF000, 32'h1357_9BDF));

        foreach (directed_plan[k]) begin
            st = directed_plan[k];
            if (st.kind == STEP_WRITE) begin
                wait_drained();
                write_reg(st.reg_idx, st.value);
            end else begin
                send_pixel(st.pixel, st.typed, st.want);
            end
        end

        // random traffic under three idle patterns
        run_stage(STAGE_ITEMS);
        sender_idle_pct = 59;
        receiver_idle_pct = 18;
        run_stage(STAGE_ITEMS);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        wait_drained();
        hold_request = 1'b1;
        run_stage(STAGE_ITEMS);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("depth_image_to_points_tb passed");
        else
            $display("depth_image_to_points_tb failed");
        $finish;
    end

endmodule
